@@ src/cubic_bspline_point_evaluator_defines.svh @@
// Assertion macros shared by the checker of the B-spline point evaluator.
`ifndef CUBIC_BSPLINE_POINT_EVALUATOR_DEFINES_SVH
`define CUBIC_BSPLINE_POINT_EVALUATOR_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define CBSPL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define CBSPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define CBSPL_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/cbspl_pkg.sv @@
// Shared widths, constants and types of the cubic B-spline point evaluator.
package cbspl_pkg;

  // Number formats.
  localparam int COORD_BITS      = 24;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int BASIS_DIVISOR   = 6;
  localparam int NUM_CELLS       = 4;

  // Parameter t carries one integer bit so that 1.0 is representable.
  localparam int T_BITS    = PARAM_FRAC_BITS + 1;
  // Basis weights stay below 16.0 in magnitude.
  localparam int WGT_BITS  = PARAM_FRAC_BITS + 5;
  localparam int PROD_BITS = WGT_BITS + COORD_BITS;
  // Four products plus the rounding offset.
  localparam int ACC_BITS  = PROD_BITS + 3;

  localparam logic [T_BITS-1:0] T_ONE = T_BITS'(longint'(1) <<< PARAM_FRAC_BITS);

  localparam longint COORD_MAX_L = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN_L = -COORD_MAX_L - 1;
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = COORD_BITS'(COORD_MAX_L);
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = COORD_BITS'(COORD_MIN_L);

  // Item operations.
  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_EVAL    = 2'd1,
    OP_TANGENT = 2'd2
  } op_t;

  // Coordinate carried by a token in the cell chain.
  typedef enum logic [1:0] {
    COORD_X = 2'd0,
    COORD_Y = 2'd1,
    COORD_Z = 2'd2
  } coord_t;

  typedef struct packed {
    logic   valid;
    coord_t idx;
  } tok_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  // One rounded and clipped coordinate leaving the rounding unit.
  typedef struct packed {
    logic                         valid;
    coord_t                       idx;
    logic                         sat;
    logic signed [COORD_BITS-1:0] value;
  } res_t;

endpackage

@@ src/cbspl_cell.sv @@
// One chain cell: holds a control point and adds its weighted coordinate to a partial sum.
module cbspl_cell
  import cbspl_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift_en,
  input  point_t                     load_point,
  output point_t                     held_point,
  input  logic signed [WGT_BITS-1:0] weight,
  input  tok_t                       tok_in,
  input  logic signed [ACC_BITS-1:0] psum_in,
  output tok_t                       tok_out,
  output logic signed [ACC_BITS-1:0] psum_out
);

  logic signed [COORD_BITS-1:0] coord;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [ACC_BITS-1:0]   psum_mid;
  tok_t                         tok_mid;

  // The window shifts by one point per push item.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_point <= '0;
    end else if (shift_en) begin
      held_point <= load_point;
    end
  end

  // Pick the coordinate named by the passing token.
  always_comb begin
    case (tok_in.idx)
      COORD_X: coord = $signed(held_point.x);
      COORD_Y: coord = $signed(held_point.y);
      COORD_Z: coord = $signed(held_point.z);
      default: coord = $signed(held_point.x);
    endcase
  end

  // First stage multiplies; the partial sum waits alongside.
  always_ff @(posedge clk) begin
    prod     <= PROD_BITS'(weight) * PROD_BITS'(coord);
    psum_mid <= psum_in;
    if (rst) begin
      tok_mid.valid <= 1'b0;
    end else begin
      tok_mid <= tok_in;
    end
  end

  // Second stage accumulates and hands the sum to the next cell.
  always_ff @(posedge clk) begin
    psum_out <= psum_mid + ACC_BITS'(prod);
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_mid;
    end
  end

endmodule

@@ src/cbspl_final.sv @@
// Rounding unit: divides the weighted sum by the basis scale, rounds and clips it.
module cbspl_final
  import cbspl_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  tok_t                       tok_in,
  input  logic signed [ACC_BITS-1:0] psum_in,
  output res_t                       res
);

  // Sum after the power-of-two part of the scale is removed.
  localparam int VAL_BITS = ACC_BITS - PARAM_FRAC_BITS;
  // Offset value in range, below BASIS_DIVISOR << COORD_BITS.
  localparam int NUM_BITS = COORD_BITS + 3;
  localparam int SHIFT    = NUM_BITS + 3;
  localparam int RCP_BITS = SHIFT + 1;
  localparam int MUL_BITS = NUM_BITS + RCP_BITS;

  localparam logic signed [ACC_BITS-1:0] RND_ADD =
    ACC_BITS'(longint'(BASIS_DIVISOR) <<< (PARAM_FRAC_BITS - 1));
  localparam longint HI_LIM_L = COORD_MAX_L * BASIS_DIVISOR + BASIS_DIVISOR - 1;
  localparam longint LO_LIM_L = COORD_MIN_L * BASIS_DIVISOR;
  localparam logic signed [VAL_BITS-1:0] HI_LIM = VAL_BITS'(HI_LIM_L);
  localparam logic signed [VAL_BITS-1:0] LO_LIM = VAL_BITS'(LO_LIM_L);
  localparam longint RCP_L = ((longint'(1) <<< SHIFT) + BASIS_DIVISOR - 1) / BASIS_DIVISOR;
  localparam logic [RCP_BITS-1:0] RCP = RCP_BITS'(RCP_L);

  logic signed [ACC_BITS-1:0] rnd_sum;
  logic signed [VAL_BITS-1:0] val1;
  logic signed [VAL_BITS-1:0] diff;
  logic [NUM_BITS-1:0]        num2;
  logic [MUL_BITS-1:0]        quo3;
  logic                       hi2, lo2, hi3, lo3;
  tok_t                       tok1, tok2, tok3;

  assign rnd_sum = psum_in + RND_ADD;
  assign diff    = val1 - LO_LIM;

  // Add half the scale and take the floor by the fraction bits.
  always_ff @(posedge clk) begin
    val1 <= rnd_sum[ACC_BITS-1:PARAM_FRAC_BITS];
    if (rst) begin
      tok1.valid <= 1'b0;
    end else begin
      tok1 <= tok_in;
    end
  end

  // Range check; in-range values are offset to be non-negative.
  always_ff @(posedge clk) begin
    hi2  <= val1 > HI_LIM;
    lo2  <= val1 < LO_LIM;
    num2 <= diff[NUM_BITS-1:0];
    if (rst) begin
      tok2.valid <= 1'b0;
    end else begin
      tok2 <= tok1;
    end
  end

  // Floor division by the divisor as a multiply by its reciprocal.
  always_ff @(posedge clk) begin
    quo3 <= MUL_BITS'(num2) * MUL_BITS'(RCP);
    hi3  <= hi2;
    lo3  <= lo2;
    if (rst) begin
      tok3.valid <= 1'b0;
    end else begin
      tok3 <= tok2;
    end
  end

  // Undo the offset by flipping the sign bit, or clip.
  always_ff @(posedge clk) begin
    res.idx <= tok3.idx;
    res.sat <= hi3 | lo3;
    if (hi3) begin
      res.value <= COORD_MAX;
    end else if (lo3) begin
      res.value <= COORD_MIN;
    end else begin
      res.value <= {~quo3[SHIFT+COORD_BITS-1], quo3[SHIFT +: COORD_BITS-1]};
    end
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= tok3.valid;
    end
  end

endmodule

@@ src/cubic_bspline_point_evaluator.sv @@
// Top level of the uniform cubic B-spline point evaluator.
//
// Input channel (in_valid/in_ready) takes one item per handshake. A push item
// (opcode 0) shifts point_x/y/z into the four-point control window and gives
// no result, and the input stays ready. Opcode 3 is dropped likewise. An
// evaluate item (opcode 1) gives the curve point and a tangent item
// (opcode 2) the derivative at param_t, values above 1.0 read as 1.0.
// An evaluate or tangent item takes these steps in order up to out_valid:
// form t^2 and then t^3, build the weights, issue the x and y tokens ahead
// of z, pass z through the four two-stage cells of the point chain and then
// the rounding unit, gather the three coordinates and load the output
// register. The input accepts again in the cycle that out_valid rises, so
// no new evaluate or tangent item is taken until the last result is loaded.
// Results sit in an output register until out_ready; a later item may be
// accepted meanwhile and its result waits in the block until the register
// frees. The saturated flag marks a result with any coordinate clipped.
// Synchronous reset clears the window to zero points and drops any pending
// result.
module cubic_bspline_point_evaluator
  import cbspl_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic [T_BITS-1:0]            param_t,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] curve_x,
  output logic signed [COORD_BITS-1:0] curve_y,
  output logic signed [COORD_BITS-1:0] curve_z,
  output logic                         saturated
);

  localparam int SQ_BITS = 2 * T_BITS;
  localparam logic [SQ_BITS-1:0] T_HALF = SQ_BITS'(longint'(1) <<< (PARAM_FRAC_BITS - 1));

  localparam logic signed [WGT_BITS-1:0] W_C3    = WGT_BITS'(3);
  localparam logic signed [WGT_BITS-1:0] W_C6    = WGT_BITS'(6);
  localparam logic signed [WGT_BITS-1:0] W_C9    = WGT_BITS'(9);
  localparam logic signed [WGT_BITS-1:0] W_C12   = WGT_BITS'(12);
  localparam logic signed [WGT_BITS-1:0] W_ONE   =
    WGT_BITS'(longint'(1) <<< PARAM_FRAC_BITS);
  localparam logic signed [WGT_BITS-1:0] W_THREE =
    WGT_BITS'(longint'(3) <<< PARAM_FRAC_BITS);
  localparam logic signed [WGT_BITS-1:0] W_FOUR  =
    WGT_BITS'(longint'(4) <<< PARAM_FRAC_BITS);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SQ    = 7'b0000010,
    ST_CUBE  = 7'b0000100,
    ST_WGT   = 7'b0001000,
    ST_ISSUE = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t                       state, state_next;
  logic                         accept, push_en, eval_go, load_out;
  logic [T_BITS-1:0]            t_clamped, t_val, t_sq, t_cu;
  logic                         is_tan;
  logic [SQ_BITS-1:0]           sq_sum, cu_sum;
  logic signed [WGT_BITS-1:0]   t_s, t2_s, t3_s;
  logic signed [WGT_BITS-1:0]   w_next [NUM_CELLS];
  logic signed [WGT_BITS-1:0]   weight [NUM_CELLS];
  coord_t                       issue_idx;
  point_t                       new_pt;
  point_t                       pts [NUM_CELLS];
  point_t                       load_pts [NUM_CELLS];
  tok_t                         tok_chain [NUM_CELLS+1];
  logic signed [ACC_BITS-1:0]   psum_chain [NUM_CELLS+1];
  res_t                         res;
  logic signed [COORD_BITS-1:0] cx, cy, cz;
  logic                         sat_acc;

  // Input handshake decode.
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign push_en   = accept && (opcode == OP_PUSH);
  assign eval_go   = accept && ((opcode == OP_EVAL) || (opcode == OP_TANGENT));
  assign load_out  = (state == ST_DONE) && (!out_valid || out_ready);
  assign t_clamped = (param_t > T_ONE) ? T_ONE : param_t;

  // Powers of t, rounded to nearest in the fraction format.
  assign sq_sum = SQ_BITS'(t_val) * SQ_BITS'(t_val) + T_HALF;
  assign cu_sum = SQ_BITS'(t_sq) * SQ_BITS'(t_val) + T_HALF;

  assign t_s  = WGT_BITS'(t_val);
  assign t2_s = WGT_BITS'(t_sq);
  assign t3_s = WGT_BITS'(t_cu);

  // Basis weights, scaled by the divisor times one.
  always_comb begin
    if (is_tan) begin
      w_next[0] = W_C6 * t_s - W_C3 * t2_s - W_THREE;
      w_next[1] = W_C9 * t2_s - W_C12 * t_s;
      w_next[2] = W_C6 * t_s - W_C9 * t2_s + W_THREE;
      w_next[3] = W_C3 * t2_s;
    end else begin
      w_next[0] = W_ONE - t3_s + W_C3 * t2_s - W_C3 * t_s;
      w_next[1] = W_C3 * t3_s - W_C6 * t2_s + W_FOUR;
      w_next[2] = W_ONE - W_C3 * t3_s + W_C3 * t2_s + W_C3 * t_s;
      w_next[3] = t3_s;
    end
  end

  // Sequencer for one evaluate or tangent item.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (eval_go) state_next = ST_SQ;
      ST_SQ:    state_next = ST_CUBE;
      ST_CUBE:  state_next = ST_WGT;
      ST_WGT:   state_next = ST_ISSUE;
      ST_ISSUE: if (issue_idx == COORD_Z) state_next = ST_DRAIN;
      ST_DRAIN: if (res.valid && (res.idx == COORD_Z)) state_next = ST_DONE;
      ST_DONE:  if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      issue_idx <= COORD_X;
      sat_acc   <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_WGT) begin
        issue_idx <= COORD_X;
      end else if (state == ST_ISSUE) begin
        case (issue_idx)
          COORD_X: issue_idx <= COORD_Y;
          COORD_Y: issue_idx <= COORD_Z;
          default: issue_idx <= COORD_X;
        endcase
      end
      if (state == ST_WGT) begin
        sat_acc <= 1'b0;
      end else if (res.valid) begin
        sat_acc <= sat_acc | res.sat;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (eval_go) begin
      t_val  <= t_clamped;
      is_tan <= (opcode == OP_TANGENT);
    end
    if (state == ST_SQ) begin
      t_sq <= sq_sum[PARAM_FRAC_BITS +: T_BITS];
    end
    if (state == ST_CUBE) begin
      t_cu <= cu_sum[PARAM_FRAC_BITS +: T_BITS];
    end
    if (state == ST_WGT) begin
      weight <= w_next;
    end
    if (res.valid) begin
      case (res.idx)
        COORD_X: cx <= res.value;
        COORD_Y: cy <= res.value;
        default: cz <= res.value;
      endcase
    end
    if (load_out) begin
      curve_x   <= cx;
      curve_y   <= cy;
      curve_z   <= cz;
      saturated <= sat_acc;
    end
  end

  // Cell chain: cell 0 holds the oldest point, the last cell the newest.
  assign new_pt        = '{x: point_x, y: point_y, z: point_z};
  assign tok_chain[0]  = '{valid: (state == ST_ISSUE), idx: issue_idx};
  assign psum_chain[0] = '0;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == NUM_CELLS - 1) begin : g_newest
      assign load_pts[i] = new_pt;
    end else begin : g_older
      assign load_pts[i] = pts[i+1];
    end

    cbspl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift_en   (push_en),
      .load_point (load_pts[i]),
      .held_point (pts[i]),
      .weight     (weight[i]),
      .tok_in     (tok_chain[i]),
      .psum_in    (psum_chain[i]),
      .tok_out    (tok_chain[i+1]),
      .psum_out   (psum_chain[i+1])
    );
  end

  cbspl_final u_final (
    .clk     (clk),
    .rst     (rst),
    .tok_in  (tok_chain[NUM_CELLS]),
    .psum_in (psum_chain[NUM_CELLS]),
    .res     (res)
  );

endmodule

@@ src/cbspl_check.sv @@
// Port-level checker for the B-spline point evaluator, bound to the top level.
`include "cubic_bspline_point_evaluator_defines.svh"

module cbspl_check
  import cbspl_pkg::*;
(
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [1:0]                   opcode,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [COORD_BITS-1:0] curve_x,
  input logic signed [COORD_BITS-1:0] curve_y,
  input logic signed [COORD_BITS-1:0] curve_z,
  input logic                         saturated
);

  logic eval_acc, quick_acc, stall, at_limit;

  assign eval_acc  = in_valid && in_ready && ((opcode == OP_EVAL) || (opcode == OP_TANGENT));
  assign quick_acc = in_valid && in_ready && (opcode != OP_EVAL) && (opcode != OP_TANGENT);
  assign stall     = out_valid && !out_ready;
  assign at_limit  = (curve_x == COORD_MAX) || (curve_x == COORD_MIN) ||
                     (curve_y == COORD_MAX) || (curve_y == COORD_MIN) ||
                     (curve_z == COORD_MAX) || (curve_z == COORD_MIN);

  // Reset drops any pending result.
  `CBSPL_ASSERT_ALWAYS(a_reset_clears, rst, !out_valid, "result valid after reset")
  // An evaluate or tangent item occupies the block after it is taken.
  `CBSPL_ASSERT_NEXT(a_eval_busy, eval_acc, !in_ready, "input ready during evaluation")
  // Push and ignored items leave the input open.
  `CBSPL_ASSERT_NEXT(a_push_quick, quick_acc, in_ready, "push item stalled the input")
  // A stalled result holds.
  `CBSPL_ASSERT_NEXT(a_out_hold, stall, out_valid && $stable(curve_x) && $stable(curve_y) && $stable(curve_z) && $stable(saturated), "result changed while stalled")
  // A saturated result has a coordinate at a range limit.
  `CBSPL_ASSERT_SAME(a_sat_limit, out_valid && saturated, at_limit, "saturated flag without clip")

endmodule

bind cubic_bspline_point_evaluator cbspl_check u_check (.*);
